// ----- design/hbd_pkg.sv -----
// Package for the HTTP body deframer: types, codes and helper functions.
package hbd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int CL_W          = 32;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BODY_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LENGTH = 1'd1;

    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHUNKED  = 2'd2;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    typedef enum logic [3:0] {
        PH_DONE    = 4'd0,
        PH_ERROR   = 4'd1,
        PH_IDENT   = 4'd2,
        PH_SIZE    = 4'd3,
        PH_EXT     = 4'd4,
        PH_SIZE_LF = 4'd5,
        PH_DATA    = 4'd6,
        PH_TAIL_CR = 4'd7,
        PH_TAIL_LF = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_FRAME    = 3'd0,
        ST_BYTE     = 3'd1,
        ST_BYTE_END = 3'd2,
        ST_END      = 3'd3,
        ST_ERROR    = 3'd4,
        ST_LEFTOVER = 3'd5
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- design/http_body_deframer.sv -----
// HTTP body deframer: removes identity and chunked framing from a byte stream.
//
// Input channel (i_in_valid / o_in_stall) carries one transaction per byte:
// i_action low starts a new body in the mode held in the body_mode register,
// i_action high delivers i_rx_byte. Every input transaction yields exactly one
// result transaction on the output channel (o_out_valid / i_out_stall) with a
// status code and, for data or leftover bytes, the byte itself.
// The result is registered at the edge that accepts the byte. The block takes
// one byte per clock unless the output stalls; the per-byte work is a single
// pass through the framing state update and the SIZE_BITS-wide length counter.
// o_in_stall is high only while a result is held and the receiver stalls, so
// a stall on the output side backs up the input side in the same cycle and
// the held result stays unchanged. Configuration registers are written at any
// edge with i_cfg_we high and are read only at a start transaction.
// Synchronous active-low reset leaves the block complete with its control
// registers cleared: bytes before any start are returned as leftover.
module http_body_deframer #(
    parameter int SIZE_BITS = hbd_pkg::SIZE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [7:0]                     o_body_byte
);
    import hbd_pkg::*;

    logic [MODE_W-1:0]    r_body_mode;
    logic [CL_W-1:0]      r_content_length;
    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_remaining, n_remaining;
    logic                 r_digits_seen, n_digits_seen;
    logic                 r_last_chunk, n_last_chunk;
    logic                 r_out_valid;
    t_status              r_status, n_status;
    logic [7:0]           r_body_byte;
    logic                 n_data;

    logic                 in_accept;
    t_hex                 hex;
    logic                 cl_fits;
    logic                 size_ovf;
    logic [SIZE_BITS-1:0] rem_dec;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_body_byte = r_body_byte;

    assign hex      = hex_decode(i_rx_byte);
    assign cl_fits  = (r_content_length >> SIZE_BITS) == '0;
    assign size_ovf = r_remaining[SIZE_BITS-1 -: 4] != 4'd0;
    assign rem_dec  = r_remaining - SIZE_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_mode      <= MODE_NONE;
            r_content_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BODY_MODE:      r_body_mode      <= i_cfg_data[MODE_W-1:0];
                CFG_CONTENT_LENGTH: r_content_length <= i_cfg_data[CL_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_remaining   = r_remaining;
        n_digits_seen = r_digits_seen;
        n_last_chunk  = r_last_chunk;
        if (i_action == ACT_START) begin
            n_remaining   = '0;
            n_digits_seen = 1'b0;
            n_last_chunk  = 1'b0;
            case (r_body_mode)
                MODE_NONE: n_phase = PH_DONE;
                MODE_IDENTITY: begin
                    if (!cl_fits) begin
                        n_phase = PH_ERROR;
                    end else if (r_content_length == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_remaining = SIZE_BITS'(r_content_length);
                        n_phase     = PH_IDENT;
                    end
                end
                MODE_CHUNKED: n_phase = PH_SIZE;
                default:      n_phase = PH_ERROR;
            endcase
        end else begin
            case (r_phase)
                PH_DONE:  ;
                PH_ERROR: ;
                PH_IDENT: begin
                    n_remaining = rem_dec;
                    if (rem_dec == '0) n_phase = PH_DONE;
                end
                PH_SIZE: begin
                    if (hex.ok) begin
                        if (size_ovf) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_remaining   = {r_remaining[SIZE_BITS-5:0], hex.value};
                            n_digits_seen = 1'b1;
                        end
                    end else if (!r_digits_seen) begin
                        if (i_rx_byte != CH_SP && i_rx_byte != CH_TAB) n_phase = PH_ERROR;
                    end else if (i_rx_byte == CH_SEMI) begin
                        n_phase = PH_EXT;
                    end else if (i_rx_byte == CH_CR) begin
                        n_phase = PH_SIZE_LF;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_EXT: begin
                    if (i_rx_byte == CH_CR) n_phase = PH_SIZE_LF;
                end
                PH_SIZE_LF: begin
                    if (i_rx_byte != CH_LF) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_digits_seen = 1'b0;
                        if (r_remaining == '0) begin
                            n_last_chunk = 1'b1;
                            n_phase      = PH_TAIL_CR;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_remaining = rem_dec;
                    if (rem_dec == '0) n_phase = PH_TAIL_CR;
                end
                PH_TAIL_CR: begin
                    n_phase = (i_rx_byte == CH_CR) ? PH_TAIL_LF : PH_ERROR;
                end
                PH_TAIL_LF: begin
                    if (i_rx_byte != CH_LF) begin
                        n_phase = PH_ERROR;
                    end else if (r_last_chunk) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_remaining = '0;
                        n_phase     = PH_SIZE;
                    end
                end
                default: n_phase = PH_ERROR;
            endcase
        end
    end

    // result
    always_comb begin
        n_status = ST_FRAME;
        n_data   = 1'b0;
        if (i_action == ACT_START) begin
            case (r_body_mode)
                MODE_NONE: n_status = ST_END;
                MODE_IDENTITY: begin
                    if (!cl_fits)                     n_status = ST_ERROR;
                    else if (r_content_length == '0) n_status = ST_END;
                    else                              n_status = ST_FRAME;
                end
                MODE_CHUNKED: n_status = ST_FRAME;
                default:      n_status = ST_ERROR;
            endcase
        end else begin
            case (r_phase)
                PH_DONE: begin
                    n_status = ST_LEFTOVER;
                    n_data   = 1'b1;
                end
                PH_ERROR: n_status = ST_ERROR;
                PH_IDENT: begin
                    n_status = (rem_dec == '0) ? ST_BYTE_END : ST_BYTE;
                    n_data   = 1'b1;
                end
                PH_SIZE: begin
                    if (hex.ok) begin
                        n_status = size_ovf ? ST_ERROR : ST_FRAME;
                    end else if (!r_digits_seen) begin
                        if (i_rx_byte != CH_SP && i_rx_byte != CH_TAB) n_status = ST_ERROR;
                    end else if (i_rx_byte != CH_SEMI && i_rx_byte != CH_CR) begin
                        n_status = ST_ERROR;
                    end
                end
                PH_EXT: n_status = ST_FRAME;
                PH_SIZE_LF: begin
                    if (i_rx_byte != CH_LF) n_status = ST_ERROR;
                end
                PH_DATA: begin
                    n_status = ST_BYTE;
                    n_data   = 1'b1;
                end
                PH_TAIL_CR: begin
                    if (i_rx_byte != CH_CR) n_status = ST_ERROR;
                end
                PH_TAIL_LF: begin
                    if (i_rx_byte != CH_LF) n_status = ST_ERROR;
                    else if (r_last_chunk)  n_status = ST_END;
                end
                default: n_status = ST_ERROR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_DONE;
            r_remaining   <= '0;
            r_digits_seen <= 1'b0;
            r_last_chunk  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase       <= n_phase;
                r_remaining   <= n_remaining;
                r_digits_seen <= n_digits_seen;
                r_last_chunk  <= n_last_chunk;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status    <= n_status;
            r_body_byte <= n_data ? i_rx_byte : 8'd0;
        end
    end

endmodule

// ----- tb/http_body_deframer_tb.sv -----
`timescale 1ns / 100ps
// Testbench for http_body_deframer: directed and random bodies against a deframing predictor.
module http_body_deframer_tb;
    import hbd_pkg::*;

    localparam int SIZE_W = SIZE_BITS_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        t_status    status;
        logic [7:0] body_byte;
    } t_deframe_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_action;
    logic [7:0]            i_rx_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [2:0]            o_status;
    logic [7:0]            o_body_byte;

    // predictor state and register mirror
    t_phase            frame_ph    = PH_DONE;
    logic [SIZE_W-1:0] count_left  = '0;
    logic              got_digit   = 1'b0;
    logic              final_chunk = 1'b0;
    logic [MODE_W-1:0] mode_cfg    = MODE_NONE;
    logic [CL_W-1:0]   len_cfg     = '0;

    t_deframe_res expected_results[$];
    logic [7:0]   body_seq[$];
    int           mismatches      = 0;
    int           items_sent      = 0;
    int           sender_idle_pct = 0;
    int           stall_pct       = 0;

    http_body_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_body_byte (o_body_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_deframe_res deframe_step(input logic act, input logic [7:0] c);
        t_deframe_res r;
        logic         hex_ok;
        logic [3:0]   nib;
        logic         bad;
        r.status    = ST_FRAME;
        r.body_byte = 8'h00;
        bad         = 1'b0;
        hex_ok = (c >= 8'h30 && c <= 8'h39) || ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66);
        nib    = c[6] ? c[3:0] + 4'd9 : c[3:0];
        if (act == ACT_START) begin
            count_left  = '0;
            got_digit   = 1'b0;
            final_chunk = 1'b0;
            case (mode_cfg)
                MODE_NONE: begin
                    frame_ph = PH_DONE;
                    r.status = ST_END;
                end
                MODE_IDENTITY: begin
                    if ((64'(len_cfg) >> SIZE_W) != 0) begin
                        bad = 1'b1;
                    end else if (len_cfg == '0) begin
                        frame_ph = PH_DONE;
                        r.status = ST_END;
                    end else begin
                        count_left = SIZE_W'(len_cfg);
                        frame_ph   = PH_IDENT;
                    end
                end
                MODE_CHUNKED: frame_ph = PH_SIZE;
                default: bad = 1'b1;
            endcase
        end else begin
            case (frame_ph)
                PH_DONE: begin
                    r.status    = ST_LEFTOVER;
                    r.body_byte = c;
                end
                PH_IDENT: begin
                    r.body_byte = c;
                    count_left  = count_left - 1'b1;
                    if (count_left == '0) begin
                        frame_ph = PH_DONE;
                        r.status = ST_BYTE_END;
                    end else begin
                        r.status = ST_BYTE;
                    end
                end
                PH_SIZE: begin
                    if (hex_ok) begin
                        // another digit would not fit the counter
                        if (count_left[SIZE_W-1 -: 4] != 4'd0) begin
                            bad = 1'b1;
                        end else begin
                            count_left = {count_left[SIZE_W-5:0], nib};
                            got_digit  = 1'b1;
                        end
                    end else if (!got_digit) begin
                        if (c != CH_SP && c != CH_TAB) bad = 1'b1;
                    end else if (c == CH_SEMI) begin
                        frame_ph = PH_EXT;
                    end else if (c == CH_CR) begin
                        frame_ph = PH_SIZE_LF;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_EXT: begin
                    if (c == CH_CR) frame_ph = PH_SIZE_LF;
                end
                PH_SIZE_LF: begin
                    if (c != CH_LF) begin
                        bad = 1'b1;
                    end else begin
                        got_digit = 1'b0;
                        if (count_left == '0) begin
                            final_chunk = 1'b1;
                            frame_ph    = PH_TAIL_CR;
                        end else begin
                            frame_ph = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    r.status    = ST_BYTE;
                    r.body_byte = c;
                    count_left  = count_left - 1'b1;
                    if (count_left == '0) frame_ph = PH_TAIL_CR;
                end
                PH_TAIL_CR: begin
                    if (c != CH_CR) bad = 1'b1;
                    else frame_ph = PH_TAIL_LF;
                end
                PH_TAIL_LF: begin
                    if (c != CH_LF) begin
                        bad = 1'b1;
                    end else if (final_chunk) begin
                        frame_ph = PH_DONE;
                        r.status = ST_END;
                    end else begin
                        count_left = '0;
                        frame_ph   = PH_SIZE;
                    end
                end
                default: bad = 1'b1;
            endcase
        end
        if (bad) begin
            frame_ph    = PH_ERROR;
            r.status    = ST_ERROR;
            r.body_byte = 8'h00;
        end
        return r;
    endfunction

    task automatic send_txn(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(deframe_step(act, b));
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] mode_word,
                              input logic [CFG_DATA_W-1:0] length);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BODY_MODE;
        i_cfg_data  <= mode_word;
        @(posedge i_clk);
        i_cfg_index <= CFG_CONTENT_LENGTH;
        i_cfg_data  <= length;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_cfg = mode_word[MODE_W-1:0];
        len_cfg  = length[CL_W-1:0];
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // size line: optional blanks and leading zero, digits, optional extension, CRLF
    task automatic add_size_line(input logic [31:0] val, input bit extra_digit);
        int         nd;
        logic [7:0] b;
        repeat ($urandom_range(0, 2)) body_seq.push_back($urandom_range(1) ? CH_SP : CH_TAB);
        repeat ($urandom_range(0, 1)) body_seq.push_back(8'h30);
        nd = 1;
        for (int i = 1; i < 8; i++) begin
            if (val[4*i +: 4] != 4'd0) nd = i + 1;
        end
        for (int i = nd - 1; i >= 0; i--) body_seq.push_back(hex_char(val[4*i +: 4]));
        if (extra_digit) body_seq.push_back(hex_char(4'($urandom)));
        if ($urandom_range(3) == 0) begin
            body_seq.push_back(CH_SEMI);
            repeat ($urandom_range(0, 4)) begin
                b = 8'($urandom);
                if (b == CH_CR) b = CH_SEMI;
                body_seq.push_back(b);
            end
        end
        body_seq.push_back(CH_CR);
        body_seq.push_back(CH_LF);
    endtask

    task automatic send_chunked_body();
        int          kind;
        int          sz;
        logic [31:0] big;
        body_seq.delete();
        kind = $urandom_range(99);
        if (kind < 80) begin
            repeat ($urandom_range(0, 3)) begin
                sz = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
                add_size_line(32'(sz), 1'b0);
                repeat (sz) body_seq.push_back(8'($urandom));
                body_seq.push_back(CH_CR);
                body_seq.push_back(CH_LF);
            end
            add_size_line(32'd0, 1'b0);
            body_seq.push_back(CH_CR);
            body_seq.push_back(CH_LF);
            // broken framing somewhere in the body
            if (kind >= 65) body_seq[$urandom_range(body_seq.size() - 1)] = 8'($urandom);
        end else if (kind < 90) begin
            big     = $urandom;
            big[28] = 1'b1;
            add_size_line(big, 1'b1);
            repeat ($urandom_range(0, 3)) body_seq.push_back(8'($urandom));
        end else begin
            // huge chunk, abandoned by the next start
            big = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom;
            if (big == '0) big = 32'd1;
            add_size_line(big, 1'b0);
            repeat ($urandom_range(0, 4)) body_seq.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) body_seq.push_back(8'($urandom));
        send_txn(ACT_START, 8'($urandom));
        foreach (body_seq[i]) send_txn(ACT_BYTE, body_seq[i]);
    endtask

    task automatic send_identity_body();
        int n;
        if (len_cfg > 32'd64) n = $urandom_range(0, 5);
        else if ($urandom_range(9) == 0) n = $urandom_range(0, int'(len_cfg));
        else n = int'(len_cfg) + $urandom_range(0, 2);
        send_txn(ACT_START, 8'($urandom));
        repeat (n) send_txn(ACT_BYTE, 8'($urandom));
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall, input int n_items);
        int                    stop_at;
        int                    r;
        logic [MODE_W-1:0]     gm;
        logic [CFG_DATA_W-1:0] mw;
        logic [CFG_DATA_W-1:0] len;
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        stop_at         = items_sent + n_items;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 55) gm = MODE_CHUNKED;
            else if (r < 83) gm = MODE_IDENTITY;
            else if (r < 93) gm = MODE_NONE;
            else gm = MODE_UNUSED;
            r = $urandom_range(9);
            if (r < 6) len = $urandom_range(1, 24);
            else if (r == 6) len = '0;
            else if (r == 7) len = 32'hFFFF_FFFF;
            else len = $urandom;
            mw = $urandom;
            if ($urandom_range(1)) mw = '0;
            mw[MODE_W-1:0] = gm;
            wait_drained();
            set_config(mw, len);
            repeat ($urandom_range(1, 6)) begin
                case (gm)
                    MODE_CHUNKED: send_chunked_body();
                    MODE_IDENTITY: send_identity_body();
                    default: begin
                        send_txn(ACT_START, 8'($urandom));
                        repeat ($urandom_range(0, 3)) send_txn(ACT_BYTE, 8'($urandom));
                    end
                endcase
            end
        end
    endtask

    task automatic test_before_start();
        send_txn(ACT_BYTE, 8'hFF);
        send_txn(ACT_BYTE, 8'h00);
        send_txn(ACT_START, 8'h5A);
    endtask

    task automatic test_identity_body();
        wait_drained();
        set_config(32'(MODE_IDENTITY), 32'd1);
        send_txn(ACT_START, 8'h00);
        send_txn(ACT_BYTE, 8'h80);
        wait_drained();
        set_config(32'(MODE_IDENTITY), 32'hFFFF_FFFF);
        send_txn(ACT_START, 8'h00);
        send_txn(ACT_BYTE, 8'h7F);
        send_txn(ACT_START, 8'h00);
        wait_drained();
        set_config(32'(MODE_IDENTITY), 32'd0);
        send_txn(ACT_START, 8'h00);
    endtask

    task automatic test_unused_mode();
        wait_drained();
        set_config(32'hFFFF_FFFF, 32'd0);
        send_txn(ACT_START, 8'h00);
        send_txn(ACT_BYTE, CH_LF);
    endtask

    task automatic test_chunked_body();
        wait_drained();
        set_config(32'(MODE_CHUNKED), 32'd5);
        send_txn(ACT_START, 8'h00);
        body_seq = '{CH_SP, CH_TAB, 8'h31, CH_SEMI, CH_CR, CH_LF, 8'hA5};
        foreach (body_seq[i]) send_txn(ACT_BYTE, body_seq[i]);
        // hold off mid-body until everything is back
        wait_drained();
        body_seq = '{CH_CR, CH_LF, 8'h30, CH_CR, CH_LF, CH_CR, CH_LF, 8'h7E};
        foreach (body_seq[i]) send_txn(ACT_BYTE, body_seq[i]);
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 225);
        run_random_phase(74, 0, 225);
        run_random_phase(0, 74, 225);
        run_random_phase(7, 7, 225);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_deframe_res exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual status %0d byte %02h",
                         $time, o_status, o_body_byte);
                mismatches++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status || o_body_byte !== exp_r.body_byte) begin
                    $display("%0t: mismatch: expected status %0d byte %02h, actual status %0d byte %02h",
                             $time, exp_r.status, exp_r.body_byte, o_status, o_body_byte);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_BODY_MODE;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_START;
        i_rx_byte   <= 8'h00;
        i_out_stall <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_before_start();
        test_identity_body();
        test_unused_mode();
        test_chunked_body();
        test_random_traffic();
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("http_body_deframer_tb: PASS");
        end else begin
            $display("http_body_deframer_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("http_body_deframer_tb: FAIL");
        $finish;
    end

endmodule
